// ===== rtl/rpc_pkg.sv =====
// Shared types, constants and the arctangent table of the rectangular/polar converter.
`timescale 1ns / 1ps
package rpc_pkg;

  localparam int IN_W = 32;
  localparam int OA_W = 33;
  localparam int OB_W = 32;
  localparam int IN_TDATA_W = 64;
  localparam int OUT_TDATA_W = 72;

  localparam int DEF_FRAC_BITS = 16;
  localparam int DEF_STAGES = 24;

  // Datapath widths: coordinates carry GUARD extra fraction bits, angles ANG_BITS.
  localparam int GUARD = 24;
  localparam int ANG_BITS = 32;
  localparam int XW = 60;
  localparam int ZW = 42;
  localparam int MW = XW - 1;
  localparam int SW = XW - GUARD;

  // Angle reduction modulo 360 degrees is done as a reduction modulo 45 of the
  // angle shifted right by three plus the fraction bits.
  localparam int UW = 24;
  localparam int RW = 25;
  localparam int RSH = 30;
  localparam int QW = UW + RW - RSH;
  localparam logic [RW-1:0] RECIP_45 = 25'd23860929;
  localparam logic [UW-1:0] MOD_OFFSET = 24'd5898240;
  localparam logic [6:0] ANGLE_MOD = 7'd45;

  localparam logic [31:0] GAIN_Q32 = 32'd2608131496;
  localparam logic signed [ZW-1:0] HALF_TURN = 42'sd773094113280;
  localparam logic signed [ZW-1:0] QUARTER_TURN = 42'sd386547056640;

  typedef enum logic {
    FUNC_RECT2POL = 1'b0,
    FUNC_POL2RECT = 1'b1
  } func_t;

  typedef struct packed {
    logic  vld;
    func_t func;
    logic  zero;
    logic  neg;
  } ctl_t;

  // atan(2^-i) in degrees with ANG_BITS fraction bits, rounded.
  function automatic logic [ZW-1:0] atan_deg(input int idx);
    logic [ZW-1:0] v;
    unique case (idx)
      0:  v = 42'd193273528320;
      1:  v = 42'd114096026022;
      2:  v = 42'd60285206654;
      3:  v = 42'd30601712202;
      4:  v = 42'd15360239180;
      5:  v = 42'd7687607525;
      6:  v = 42'd3844741810;
      7:  v = 42'd1922488225;
      8:  v = 42'd961258780;
      9:  v = 42'd480631223;
      10: v = 42'd240315841;
      11: v = 42'd120157949;
      12: v = 42'd60078978;
      13: v = 42'd30039489;
      14: v = 42'd15019745;
      15: v = 42'd7509872;
      16: v = 42'd3754936;
      17: v = 42'd1877468;
      18: v = 42'd938734;
      19: v = 42'd469367;
      20: v = 42'd234684;
      21: v = 42'd117342;
      22: v = 42'd58671;
      23: v = 42'd29335;
      24: v = 42'd14668;
      25: v = 42'd7334;
      26: v = 42'd3667;
      27: v = 42'd1833;
      28: v = 42'd917;
      29: v = 42'd458;
      30: v = 42'd229;
      31: v = 42'd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/rpc_prep.sv =====
// Input conditioning: scaling, half-plane turn, angle reduction and quadrant fold.
`timescale 1ns / 1ps
module rpc_prep import rpc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  func_t                 in_func,
  input  logic signed [IN_W-1:0] in_a,
  input  logic signed [IN_W-1:0] in_b,
  output ctl_t                  ctl_o,
  output logic signed [XW-1:0]  x_o,
  output logic signed [XW-1:0]  y_o,
  output logic signed [ZW-1:0]  z_o
);

  localparam int LOW_BITS = FRAC_BITS + 3;
  localparam logic [33:0] LOW_MASK = (34'd1 << LOW_BITS) - 34'd1;

  ctl_t ctl1_r, ctl1_nxt, ctl2_r, ctl3_r, ctl4_r, ctl4_nxt;
  logic signed [XW-1:0] x1_r, x1_nxt, y1_r, y1_nxt, x2_r, y2_r, x3_r, y3_r, x4_r, y4_r;
  logic signed [ZW-1:0] z1_r, z1_nxt, z2_r, z3_r, z3_nxt, z4_r, z4_nxt;
  logic [UW-1:0] u1_r, u1_nxt, u2_r;
  logic [33:0] low1_r, low1_nxt, low2_r;
  logic [QW-1:0] q2_r, q2_nxt;

  logic signed [XW-1:0] a_w, b_w;
  logic signed [33:0] bp, bv;
  logic [UW+RW-1:0] prod;
  logic [UW-1:0] rem, q45;
  logic [6:0] r7;
  logic [5:0] r6;
  logic [ZW-1:0] zraw;
  logic signed [ZW-1:0] zt;

  // Stage 1: scale the coordinates, turn left half-plane vectors, offset the angle by 180 degrees.
  always_comb begin
    a_w = XW'(in_a) <<< GUARD;
    b_w = XW'(in_b) <<< GUARD;
    ctl1_nxt.vld = in_vld;
    ctl1_nxt.func = in_func;
    ctl1_nxt.zero = (in_a == '0) && (in_b == '0);
    ctl1_nxt.neg = 1'b0;
    x1_nxt = a_w;
    y1_nxt = '0;
    z1_nxt = '0;
    if (in_func == FUNC_RECT2POL) begin
      y1_nxt = b_w;
      // A vector in the left half-plane is turned by 180 degrees first.
      if (in_a[IN_W-1]) begin
        x1_nxt = -a_w;
        y1_nxt = -b_w;
        z1_nxt = in_b[IN_W-1] ? -HALF_TURN : HALF_TURN;
      end
    end
    bp = 34'(in_b) + (34'sd180 <<< FRAC_BITS);
    bv = bp >>> LOW_BITS;
    u1_nxt = UW'(bv + 34'(MOD_OFFSET));
    low1_nxt = bp & LOW_MASK;
  end

  // Stage 2: quotient estimate by reciprocal multiplication.
  always_comb begin
    prod = (UW+RW)'(u1_r) * (UW+RW)'(RECIP_45);
    q2_nxt = prod[UW+RW-1:RSH];
  end

  // Stage 3: remainder with one correction, then, for polar input, the reduced angle in [-180, 180).
  always_comb begin
    q45 = UW'(q2_r) * UW'(ANGLE_MOD);
    rem = u2_r - q45;
    r7 = rem[6:0];
    r6 = (r7 >= ANGLE_MOD) ? 6'(r7 - ANGLE_MOD) : r7[5:0];
    zraw = (ZW'(r6) << LOW_BITS) | ZW'(low2_r);
    zt = $signed(zraw) - $signed(ZW'(180) << FRAC_BITS);
    z3_nxt = (ctl2_r.func == FUNC_POL2RECT) ? (zt <<< (ANG_BITS - FRAC_BITS)) : z2_r;
  end

  // Stage 4: fold angles beyond a quarter turn and remember to negate the result.
  always_comb begin
    ctl4_nxt = ctl3_r;
    z4_nxt = z3_r;
    if (ctl3_r.func == FUNC_POL2RECT) begin
      if (z3_r > QUARTER_TURN) begin
        z4_nxt = z3_r - HALF_TURN;
        ctl4_nxt.neg = 1'b1;
      end else if (z3_r < -QUARTER_TURN) begin
        z4_nxt = z3_r + HALF_TURN;
        ctl4_nxt.neg = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
      ctl4_r.vld <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= ctl1_nxt.vld;
      ctl2_r.vld <= ctl1_r.vld;
      ctl3_r.vld <= ctl2_r.vld;
      ctl4_r.vld <= ctl4_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.func <= ctl1_nxt.func;
      ctl1_r.zero <= ctl1_nxt.zero;
      ctl1_r.neg <= ctl1_nxt.neg;
      ctl2_r.func <= ctl1_r.func;
      ctl2_r.zero <= ctl1_r.zero;
      ctl2_r.neg <= ctl1_r.neg;
      ctl3_r.func <= ctl2_r.func;
      ctl3_r.zero <= ctl2_r.zero;
      ctl3_r.neg <= ctl2_r.neg;
      ctl4_r.func <= ctl4_nxt.func;
      ctl4_r.zero <= ctl4_nxt.zero;
      ctl4_r.neg <= ctl4_nxt.neg;
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
      z1_r <= z1_nxt;
      u1_r <= u1_nxt;
      low1_r <= low1_nxt;
      x2_r <= x1_r;
      y2_r <= y1_r;
      z2_r <= z1_r;
      u2_r <= u1_r;
      low2_r <= low1_r;
      q2_r <= q2_nxt;
      x3_r <= x2_r;
      y3_r <= y2_r;
      z3_r <= z3_nxt;
      x4_r <= x3_r;
      y4_r <= y3_r;
      z4_r <= z4_nxt;
    end
  end

  assign ctl_o = ctl4_r;
  assign x_o = x4_r;
  assign y_o = y4_r;
  assign z_o = z4_r;

endmodule

// ===== rtl/rpc_cordic_stage.sv =====
// One registered CORDIC micro-rotation, vectoring or rotation by the item's mode.
`timescale 1ns / 1ps
module rpc_cordic_stage import rpc_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output ctl_t                 ctl_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o
);

  localparam logic signed [ZW-1:0] ATAN = $signed(atan_deg(IDX));

  ctl_t ctl_r;
  logic signed [XW-1:0] x_r, x_nxt, y_r, y_nxt, dx, dy;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic up;

  always_comb begin
    dx = y_i >>> IDX;
    dy = x_i >>> IDX;
    unique case (ctl_i.func)
      FUNC_RECT2POL: up = !y_i[XW-1];
      FUNC_POL2RECT: up = !z_i[ZW-1];
      default:       up = 1'b0;
    endcase
    // Vectoring drives y to zero, rotation drives z to zero.
    if ((ctl_i.func == FUNC_RECT2POL) == up) begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_i.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r.func <= ctl_i.func;
      ctl_r.zero <= ctl_i.zero;
      ctl_r.neg <= ctl_i.neg;
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign ctl_o = ctl_r;
  assign x_o = x_r;
  assign y_o = y_r;
  assign z_o = z_r;

endmodule

// ===== rtl/rpc_post.sv =====
// Output stages: gain compensation, rounding, sign restore and saturation.
`timescale 1ns / 1ps
module rpc_post import rpc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  ctl_t                 ctl_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  output logic                 vld_o,
  output logic [OA_W-1:0]      a_o,
  output logic [OB_W-1:0]      b_o
);

  localparam int ASH = ANG_BITS - FRAC_BITS;

  function automatic logic [OA_W-1:0] sat_a(input logic signed [SW:0] v);
    logic [OA_W-1:0] r;
    if (v > $signed((SW+1)'({1'b0, {(OA_W-1){1'b1}}}))) begin
      r = {1'b0, {(OA_W-1){1'b1}}};
    end else if (v < -$signed((SW+1)'({1'b0, {(OA_W-1){1'b1}}})) - 1) begin
      r = {1'b1, {(OA_W-1){1'b0}}};
    end else begin
      r = v[OA_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [OB_W-1:0] sat_b(input logic signed [ZW-1:0] v);
    logic [OB_W-1:0] r;
    if (v > $signed(ZW'({1'b0, {(OB_W-1){1'b1}}}))) begin
      r = {1'b0, {(OB_W-1){1'b1}}};
    end else if (v < -$signed(ZW'({1'b0, {(OB_W-1){1'b1}}})) - 1) begin
      r = {1'b1, {(OB_W-1){1'b0}}};
    end else begin
      r = v[OB_W-1:0];
    end
    return r;
  endfunction

  ctl_t ctl1_r, ctl2_r, ctl3_r;
  logic vld4_r;
  logic xs1_r, ys1_r, xs2_r, ys2_r, xs3_r, ys3_r;
  logic [MW-1:0] xm1_r, xm1_nxt, ym1_r, ym1_nxt;
  logic signed [ZW-1:0] ang1_r, ang1_nxt, ang2_r, ang3_r, zr;
  logic [MW-1:0] xhp2_r, xhp2_nxt, yhp2_r, yhp2_nxt;
  logic [31:0] xlp2_r, xlp2_nxt, ylp2_r, ylp2_nxt;
  logic [XW-1:0] xsum, ysum;
  logic [SW-1:0] xr3_r, xr3_nxt, yr3_r, yr3_nxt;
  logic signed [SW:0] va, vb;
  logic [OA_W-1:0] a4_r, a4_nxt;
  logic [OB_W-1:0] b4_r, b4_nxt;

  // Stage 1: magnitudes and the rounded output angle.
  always_comb begin
    xm1_nxt = x_i[XW-1] ? MW'(-x_i) : MW'(x_i);
    ym1_nxt = y_i[XW-1] ? MW'(-y_i) : MW'(y_i);
    zr = z_i + $signed(ZW'(1) << (ASH - 1));
    ang1_nxt = zr >>> ASH;
  end

  // Stage 2: gain as two partial products with the 32-bit gain, the low one truncated.
  always_comb begin
    xhp2_nxt = MW'(64'(xm1_r[MW-1:32]) * 64'(GAIN_Q32));
    yhp2_nxt = MW'(64'(ym1_r[MW-1:32]) * 64'(GAIN_Q32));
    xlp2_nxt = 32'((64'(xm1_r[31:0]) * 64'(GAIN_Q32)) >> 32);
    ylp2_nxt = 32'((64'(ym1_r[31:0]) * 64'(GAIN_Q32)) >> 32);
  end

  // Stage 3: drop the guard bits, rounding half away from zero on the magnitude.
  always_comb begin
    xsum = XW'(xhp2_r) + XW'(xlp2_r) + (XW'(1) << (GUARD - 1));
    ysum = XW'(yhp2_r) + XW'(ylp2_r) + (XW'(1) << (GUARD - 1));
    xr3_nxt = xsum[XW-1:GUARD];
    yr3_nxt = ysum[XW-1:GUARD];
  end

  // Stage 4: restore signs, undo the fold, saturate and clear the result of a zero vector.
  always_comb begin
    va = (xs3_r ^ ctl3_r.neg) ? -$signed({1'b0, xr3_r}) : $signed({1'b0, xr3_r});
    vb = (ys3_r ^ ctl3_r.neg) ? -$signed({1'b0, yr3_r}) : $signed({1'b0, yr3_r});
    a4_nxt = sat_a(va);
    unique case (ctl3_r.func)
      FUNC_RECT2POL: b4_nxt = sat_b(ang3_r);
      FUNC_POL2RECT: b4_nxt = sat_b(ZW'(vb));
      default:       b4_nxt = '0;
    endcase
    if (ctl3_r.zero && ctl3_r.func == FUNC_RECT2POL) begin
      a4_nxt = '0;
      b4_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r.vld <= 1'b0;
      ctl2_r.vld <= 1'b0;
      ctl3_r.vld <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      ctl1_r.vld <= ctl_i.vld;
      ctl2_r.vld <= ctl1_r.vld;
      ctl3_r.vld <= ctl2_r.vld;
      vld4_r <= ctl3_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1_r.func <= ctl_i.func;
      ctl1_r.zero <= ctl_i.zero;
      ctl1_r.neg <= ctl_i.neg;
      ctl2_r.func <= ctl1_r.func;
      ctl2_r.zero <= ctl1_r.zero;
      ctl2_r.neg <= ctl1_r.neg;
      ctl3_r.func <= ctl2_r.func;
      ctl3_r.zero <= ctl2_r.zero;
      ctl3_r.neg <= ctl2_r.neg;
      xs1_r <= x_i[XW-1];
      ys1_r <= y_i[XW-1];
      xm1_r <= xm1_nxt;
      ym1_r <= ym1_nxt;
      ang1_r <= ang1_nxt;
      xs2_r <= xs1_r;
      ys2_r <= ys1_r;
      xhp2_r <= xhp2_nxt;
      yhp2_r <= yhp2_nxt;
      xlp2_r <= xlp2_nxt;
      ylp2_r <= ylp2_nxt;
      ang2_r <= ang1_r;
      xs3_r <= xs2_r;
      ys3_r <= ys2_r;
      xr3_r <= xr3_nxt;
      yr3_r <= yr3_nxt;
      ang3_r <= ang2_r;
      a4_r <= a4_nxt;
      b4_r <= b4_nxt;
    end
  end

  assign vld_o = vld4_r;
  assign a_o = a4_r;
  assign b_o = b4_r;

endmodule

// ===== rtl/rect_polar_converter_unit.sv =====
// Top level: pipelined CORDIC converter between rectangular and polar form, degrees.
// Throughput: one item per cycle while the skid register is empty; four prep, STAGES
// rotation and four output stages, then the output register.
// A skid register behind the output register keeps in_tready high while one result waits.
// Reset: synchronous, active low; clears all valid bits, so the pipeline comes up empty.
`timescale 1ns / 1ps
module rect_polar_converter_unit import rpc_pkg::*; #(
  parameter int FRAC_BITS = DEF_FRAC_BITS,
  parameter int STAGES = DEF_STAGES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // in_a [31:0], in_b [63:32]
  input  logic                   in_tuser,   // func [0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata   // out_a [32:0], out_b [64:33], zeros [71:65]
);

  logic en;
  ctl_t ctl_s [STAGES+1];
  logic signed [XW-1:0] x_s [STAGES+1];
  logic signed [XW-1:0] y_s [STAGES+1];
  logic signed [ZW-1:0] z_s [STAGES+1];

  logic post_vld, push;
  logic [OA_W-1:0] post_a;
  logic [OB_W-1:0] post_b;
  logic [OUT_TDATA_W-1:0] push_data;

  logic out_v_r, out_v_nxt, skid_v_r, skid_v_nxt;
  logic [OUT_TDATA_W-1:0] out_data_r, out_data_nxt, skid_data_r, skid_data_nxt;

  // The whole pipeline advances unless the skid register is occupied.
  assign en = !skid_v_r;
  assign in_tready = en;

  rpc_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_tvalid),
    .in_func (func_t'(in_tuser)),
    .in_a    ($signed(in_tdata[IN_W-1:0])),
    .in_b    ($signed(in_tdata[2*IN_W-1:IN_W])),
    .ctl_o   (ctl_s[0]),
    .x_o     (x_s[0]),
    .y_o     (y_s[0]),
    .z_o     (z_s[0])
  );

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    rpc_cordic_stage #(.IDX(i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .ctl_i (ctl_s[i]),
      .x_i   (x_s[i]),
      .y_i   (y_s[i]),
      .z_i   (z_s[i]),
      .ctl_o (ctl_s[i+1]),
      .x_o   (x_s[i+1]),
      .y_o   (y_s[i+1]),
      .z_o   (z_s[i+1])
    );
  end

  rpc_post #(.FRAC_BITS(FRAC_BITS)) u_post (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .ctl_i (ctl_s[STAGES]),
    .x_i   (x_s[STAGES]),
    .y_i   (y_s[STAGES]),
    .z_i   (z_s[STAGES]),
    .vld_o (post_vld),
    .a_o   (post_a),
    .b_o   (post_b)
  );

  assign push = post_vld && en;
  assign push_data = {(OUT_TDATA_W - OA_W - OB_W)'(0), post_b, post_a};

  always_comb begin
    out_v_nxt = out_v_r;
    out_data_nxt = out_data_r;
    skid_v_nxt = skid_v_r;
    skid_data_nxt = skid_data_r;
    if (!out_v_r || out_tready) begin
      out_v_nxt = skid_v_r || push;
      out_data_nxt = skid_v_r ? skid_data_r : push_data;
      skid_v_nxt = 1'b0;
    end else if (push) begin
      skid_v_nxt = 1'b1;
      skid_data_nxt = push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tdata = out_data_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid register holds an item while the output register is empty");

  a_skid_fill_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(skid_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid register filled without a stalled output");

  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && out_tready |=> out_v_r && (out_data_r == $past(skid_data_r)))
    else $error("skid item not moved to the output register");

  a_stall_catch: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_tready && push |=> skid_v_r && (skid_data_r == $past(push_data)))
    else $error("item from the pipeline lost during an output stall");

endmodule

// ===== tb/sv/rect_polar_converter_unit_tb.sv =====
// Self-checking testbench for the CORDIC rectangular/polar converter.
`timescale 1ns / 1ps
module rect_polar_converter_unit_tb import rpc_pkg::*;;

  localparam int N_RANDOM = 750;
  localparam int MAX_IDLE = 13;
  localparam int DRAIN_CYCLES = 2 * (DEF_STAGES + 8);

  localparam longint HALF_DEG = 64'sd773094113280;     // 180 degrees, 32 fraction bits
  localparam longint QUARTER_DEG = 64'sd386547056640;  // 90 degrees
  localparam longint FULL_DEG = 64'sd1546188226560;    // 360 degrees
  localparam bit [63:0] CORDIC_GAIN = 64'd2608131496;  // 1/K with 32 fraction bits

  localparam longint ATAN_Q32 [0:23] = '{
    64'sd193273528320, 64'sd114096026022, 64'sd60285206654, 64'sd30601712202,
    64'sd15360239180, 64'sd7687607525, 64'sd3844741810, 64'sd1922488225,
    64'sd961258780, 64'sd480631223, 64'sd240315841, 64'sd120157949,
    64'sd60078978, 64'sd30039489, 64'sd15019745, 64'sd7509872,
    64'sd3754936, 64'sd1877468, 64'sd938734, 64'sd469367,
    64'sd234684, 64'sd117342, 64'sd58671, 64'sd29335
  };

  typedef struct packed {
    logic [OA_W-1:0] a;
    logic [OB_W-1:0] b;
  } conv_result_t;

  typedef struct packed {
    func_t           f;
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    logic            known;
    logic [OA_W-1:0] ea;
    logic [OB_W-1:0] eb;
  } stim_row_t;

  localparam int N_DIRECTED = 25;

  // Q16.16: 1.0 = 0001_0000, 90 deg = 005A_0000, 180 deg = 00B4_0000.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{FUNC_RECT2POL, 32'h0000_0000, 32'h0000_0000, 1'b1, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h0001_0000, 32'h0000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'hFFFF_0000, 32'h0000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'hFFFF_0000, 32'hFFFF_FFFF, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h0000_0000, 32'h0001_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h0000_0000, 32'hFFFF_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h8000_0000, 32'h8000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h8000_0000, 32'h0000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h0000_0000, 32'h8000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'h0000_0001, 32'h0000_0001, 1'b0, 33'h0, 32'h0},
    '{FUNC_RECT2POL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0000_0000, 32'h002D_0000, 1'b1, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'h0000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'h005A_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'h00B4_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'hFF4C_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'h01C2_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h8000_0000, 32'h8000_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h8000_0000, 32'hFFA6_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'h0001_0000, 32'h005B_0000, 1'b0, 33'h0, 32'h0},
    '{FUNC_POL2RECT, 32'hFFFF_0000, 32'hFF79_0000, 1'b0, 33'h0, 32'h0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;   // in_a [31:0], in_b [63:32]
  logic                   in_tuser = 1'b0; // func [0]
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;       // out_a [32:0], out_b [64:33], zeros [71:65]

  conv_result_t pending_results [$];
  int err_count = 0;
  int checked_count = 0;
  int r2p_count = 0;
  int p2r_count = 0;
  int stall_left = 0;
  bit tx_idle_en = 1'b1;
  bit rx_idle_en = 1'b1;

  rect_polar_converter_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Removes the CORDIC gain, then drops the guard bits rounding half away from zero.
  function automatic longint apply_cordic_gain(input longint v);
    bit neg;
    bit [63:0] m;
    bit [63:0] r;
    neg = v < 0;
    m = neg ? 64'(-v) : 64'(v);
    r = (m >> 32) * CORDIC_GAIN + (((m & 64'hFFFF_FFFF) * CORDIC_GAIN) >> 32);
    r = (r + (64'd1 << (GUARD - 1))) >> GUARD;
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic conv_result_t predict_conversion(input func_t f,
                                                      input logic signed [IN_W-1:0] a_in,
                                                      input logic signed [IN_W-1:0] b_in);
    longint x, y, z, dx, dy, ra, rb;
    bit flip;
    conv_result_t r;
    ra = 0;
    rb = 0;
    if (f == FUNC_RECT2POL) begin
      if (a_in != 0 || b_in != 0) begin
        x = longint'(a_in) * (64'sd1 <<< GUARD);
        y = longint'(b_in) * (64'sd1 <<< GUARD);
        z = 0;
        // Left half plane: turn by 180 degrees first; the negative x axis lands on +180.
        if (x < 0) begin
          x = -x;
          y = -y;
          z = (b_in >= 0) ? HALF_DEG : -HALF_DEG;
        end
        for (int i = 0; i < DEF_STAGES; i++) begin
          dx = y >>> i;
          dy = x >>> i;
          if (y >= 0) begin
            x += dx; y -= dy; z += ATAN_Q32[i];
          end else begin
            x -= dx; y += dy; z -= ATAN_Q32[i];
          end
        end
        ra = apply_cordic_gain(x);
        rb = (z + (64'sd1 <<< (ANG_BITS - DEF_FRAC_BITS - 1))) >>> (ANG_BITS - DEF_FRAC_BITS);
      end
    end else begin
      z = (longint'(b_in) * (64'sd1 <<< (ANG_BITS - DEF_FRAC_BITS))) % FULL_DEG;
      x = longint'(a_in) * (64'sd1 <<< GUARD);
      y = 0;
      flip = 1'b0;
      if (z >= HALF_DEG) z -= FULL_DEG;
      if (z < -HALF_DEG) z += FULL_DEG;
      if (z > QUARTER_DEG) begin
        z -= HALF_DEG; flip = 1'b1;
      end else if (z < -QUARTER_DEG) begin
        z += HALF_DEG; flip = 1'b1;
      end
      for (int i = 0; i < DEF_STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= ATAN_Q32[i];
        end else begin
          x += dx; y -= dy; z += ATAN_Q32[i];
        end
      end
      ra = apply_cordic_gain(x);
      rb = apply_cordic_gain(y);
      if (flip) begin
        ra = -ra;
        rb = -rb;
      end
    end
    if (ra < -(64'sd1 <<< 32)) ra = -(64'sd1 <<< 32);
    if (ra > (64'sd1 <<< 32) - 1) ra = (64'sd1 <<< 32) - 1;
    if (rb < -(64'sd1 <<< 31)) rb = -(64'sd1 <<< 31);
    if (rb > (64'sd1 <<< 31) - 1) rb = (64'sd1 <<< 31) - 1;
    r.a = ra[OA_W-1:0];
    r.b = rb[OB_W-1:0];
    return r;
  endfunction

  function automatic logic [IN_W-1:0] rand_operand();
    logic [IN_W-1:0] v;
    case ($urandom_range(0, 5))
      0, 1: v = $urandom;
      2, 3: v = $urandom_range(0, 2 ** 21) - 2 ** 20;
      4: begin
        case ($urandom_range(0, 4))
          0: v = 32'h7FFF_FFFF;
          1: v = 32'h8000_0000;
          2: v = 32'h0000_0000;
          3: v = 32'h0000_0001;
          default: v = 32'hFFFF_FFFF;
        endcase
      end
      // An angle between -720 and +720 degrees.
      default: v = $urandom_range(0, 1440 * 65536) - 720 * 65536;
    endcase
    return v;
  endfunction

  // Offers one item after a random gap and records what it should produce.
  task automatic send_item(input func_t f, input logic [IN_W-1:0] a, input logic [IN_W-1:0] b,
                           input logic known, input conv_result_t typed_res);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= {b, a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(known ? typed_res : predict_conversion(f, a, b));
    if (f == FUNC_RECT2POL) r2p_count++;
    else p2r_count++;
  endtask

  // Result side: outputs are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    conv_result_t want;
    logic [OA_W-1:0] got_a;
    logic [OB_W-1:0] got_b;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_a = out_tdata[OA_W-1:0];
        got_b = out_tdata[OA_W+OB_W-1:OA_W];
        if (pending_results.size() == 0) begin
          $error("unexpected result item: out_a %0d out_b %0d", $signed(got_a), $signed(got_b));
          err_count++;
        end else begin
          want = pending_results.pop_front();
          checked_count++;
          if (got_a !== want.a) begin
            $error("out_a mismatch: expected %0d, actual %0d", $signed(want.a), $signed(got_a));
            err_count++;
          end
          if (got_b !== want.b) begin
            $error("out_b mismatch: expected %0d, actual %0d", $signed(want.b), $signed(got_b));
            err_count++;
          end
        end
        stall_left = rx_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (stall_left != 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("rect_polar_converter_unit regression: fail");
    $finish;
  end

  initial begin
    func_t f;
    conv_result_t typed_res;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      typed_res.a = directed_rows[i].ea;
      typed_res.b = directed_rows[i].eb;
      send_item(directed_rows[i].f, directed_rows[i].a, directed_rows[i].b,
                directed_rows[i].known, typed_res);
    end

    typed_res = '0;
    for (int i = 0; i < N_RANDOM; i++) begin
      // New idle pattern every 50 items, sometimes with no gaps at all.
      if (i % 50 == 0) begin
        tx_idle_en = $urandom_range(0, 3) != 0;
        rx_idle_en = $urandom_range(0, 3) != 0;
      end
      // Let the pipeline run dry once, mid-stream.
      if (i == N_RANDOM / 2) begin
        in_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
      end
      f = $urandom_range(0, 1) ? FUNC_POL2RECT : FUNC_RECT2POL;
      send_item(f, rand_operand(), rand_operand(), 1'b0, typed_res);
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Converted %0d rectangular-to-polar and %0d polar-to-rectangular items,",
             r2p_count, p2r_count);
    $display("%0d results compared, %0d errors.", checked_count, err_count);
    if (err_count == 0) begin
      $display("rect_polar_converter_unit regression: pass");
    end else begin
      $display("rect_polar_converter_unit regression: fail");
    end
    $finish;
  end

endmodule

// ===== rect_polar_converter_unit.f =====
rtl/rpc_pkg.sv
rtl/rpc_prep.sv
rtl/rpc_cordic_stage.sv
rtl/rpc_post.sv
rtl/rect_polar_converter_unit.sv
tb/sv/rect_polar_converter_unit_tb.sv
